// ===== rtl/core/spv_pkg.sv =====
// Shared constants of the sample playback voice.
package spv_pkg;

  // Item function codes.
  localparam logic [2:0] FUNC_WRITE   = 3'd0;
  localparam logic [2:0] FUNC_START   = 3'd1;
  localparam logic [2:0] FUNC_RELEASE = 3'd2;
  localparam logic [2:0] FUNC_STOP    = 3'd3;
  localparam logic [2:0] FUNC_TICK    = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_SLICE_BEGIN  = 3'd0;
  localparam logic [2:0] REG_SLICE_FINISH = 3'd1;
  localparam logic [2:0] REG_LOOP_MODE    = 3'd2;
  localparam logic [2:0] REG_LEFT_GAIN    = 3'd3;
  localparam logic [2:0] REG_RIGHT_GAIN   = 3'd4;
  localparam logic [2:0] REG_FADE_IN_LEN  = 3'd5;
  localparam logic [2:0] REG_FADE_OUT_LEN = 3'd6;
  localparam logic [2:0] REG_PITCH_STEP   = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Voice play states.
  localparam logic [1:0] PS_IDLE = 2'd0;
  localparam logic [1:0] PS_PLAY = 2'd1;
  localparam logic [1:0] PS_REL  = 2'd2;

  localparam logic [16:0] ENV_FULL = 17'h10000;
  localparam logic [19:0] CNT_MAX  = 20'hFFFFF;

  // Widest divisor: fade-out length times pitch step.
  localparam int unsigned SPAN_W = 44;
  localparam int unsigned QUOT_W = 17;

endpackage

// ===== rtl/core/spv_if.sv =====
// Valid/ready channel interfaces for the voice input items and results.
interface spv_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [11:0]       address;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, func, address, left_sample, right_sample, input ready);
  modport sink (input valid, func, address, left_sample, right_sample, output ready);
endinterface

interface spv_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic              active;

  modport source (output valid, out_left, out_right, active, input ready);
  modport sink (input valid, out_left, out_right, active, output ready);
endinterface

// ===== rtl/core/spv_divider.sv =====
// Restoring divider that yields a 17-bit quotient, one bit per cycle.
module spv_divider #(
  parameter int unsigned NUM_W = 45
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [NUM_W-1:0]              num_i,
  input  logic [spv_pkg::SPAN_W-1:0]    den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [spv_pkg::QUOT_W-1:0]    quot_o,
  output logic [NUM_W-1:0]              rem_o
);
  localparam int unsigned QW = spv_pkg::QUOT_W;
  localparam int unsigned DSW = spv_pkg::SPAN_W + QW;
  localparam int unsigned CW = (NUM_W > DSW) ? NUM_W : DSW;
  localparam int unsigned CNT_W = $clog2(QW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    r_q, d_q;
  logic [QW-1:0]    q_q;
  logic             fits;

  assign fits = (r_q >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient is known to stay below 2^17, so the divisor starts at den << 16.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= CW'(num_i);
      d_q <= CW'(den_i) << (QW - 1);
      q_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        r_q <= r_q - d_q;
      end
      q_q <= {q_q[QW-2:0], fits};
      d_q <= d_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q[NUM_W-1:0];
endmodule

// ===== rtl/core/spv_sample_store.sv =====
// Stereo sample memory with one write port and one registered read port.
module spv_sample_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/sample_playback_voice.sv =====
// Top level of the one-voice sample player with linear interpolation and envelopes.
// Write, start, release and stop items register their result at once. A tick of
// a playing voice runs under a small sequencer that shares one multiplier and
// one 17-step restoring divider. The envelope step may need a fade divide.
// The two store reads (S_RD0 to S_RD2) are followed by interpolation and
// scaling for the left and then the right side. The position update needs a
// divide when a loop wraps, and the result is handed over last, waiting while
// an earlier result is not yet taken. No new item is accepted while a
// tick is in progress or while a result waits to be taken.
module sample_playback_voice #(
  parameter int unsigned SAMPLE_DEPTH = 4096,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  spv_in_if.sink                             in_ch,
  spv_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [spv_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [spv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  localparam int unsigned POS_W = 13 + FRAC_BITS;
  localparam int unsigned NUM_W = 29 + FRAC_BITS;
  localparam int unsigned AW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned DW    = spv_pkg::SPAN_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENV0 = 4'd1;
  localparam logic [3:0] S_ENV1 = 4'd2;
  localparam logic [3:0] S_DIVW = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_INT  = 4'd7;
  localparam logic [3:0] S_SMP  = 4'd8;
  localparam logic [3:0] S_GAIN = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_POS  = 4'd11;
  localparam logic [3:0] S_MODW = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  // Configuration registers.
  logic [11:0] slice_begin_q;
  logic [12:0] slice_finish_q;
  logic        loop_mode_q;
  logic [15:0] left_gain_q, right_gain_q;
  logic [19:0] fade_in_len_q, fade_out_len_q;
  logic [23:0] pitch_step_q;

  // Voice state.
  logic [POS_W-1:0] pos_q;
  logic [1:0]       ps_q;
  logic [19:0]      elapsed_q, release_cnt_q;
  logic [16:0]      env_q, release_from_q;

  logic [3:0]  seq_q;
  logic        side_q;
  logic signed [15:0] s0_l_q, s0_r_q, s1_l_q, s1_r_q;
  logic signed [15:0] res_l_q, res_r_q;
  logic signed [58:0] p_q;

  logic        ovalid_q, oactive_q;
  logic signed [15:0] oleft_q, oright_q;

  // Derived values.
  logic [19:0]      fo, fi, rel_d;
  logic [23:0]      step;
  logic [POS_W-1:0] beg_pos, fin_pos, rem, pos_n;
  logic [12:0]      i0;
  logic [13:0]      i1;
  logic             in0, in1;
  logic [FRAC_BITS-1:0] frac;

  assign fo      = (fade_out_len_q == '0) ? 20'd1 : fade_out_len_q;
  assign fi      = (fade_in_len_q == '0) ? 20'd1 : fade_in_len_q;
  assign step    = (pitch_step_q == '0) ? 24'd1 : pitch_step_q;
  assign rel_d   = (release_cnt_q < fo) ? release_cnt_q : fo;
  assign beg_pos = POS_W'(slice_begin_q) << FRAC_BITS;
  assign fin_pos = POS_W'(slice_finish_q) << FRAC_BITS;
  assign rem     = fin_pos - pos_q;
  assign pos_n   = pos_q + POS_W'(step);
  assign i0      = pos_q[POS_W-1:FRAC_BITS];
  assign i1      = 14'(i0) + 14'd1;
  assign in0     = (32'(i0) < SAMPLE_DEPTH);
  assign in1     = (32'(i1) < SAMPLE_DEPTH);
  assign frac    = pos_q[FRAC_BITS-1:0];

  logic accept;
  assign in_ch.ready = (seq_q == S_IDLE) && (!ovalid_q || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_begin_q  <= 12'd0;
      slice_finish_q <= 13'd4096;
      loop_mode_q    <= 1'b0;
      left_gain_q    <= 16'd32768;
      right_gain_q   <= 16'd32768;
      fade_in_len_q  <= 20'd1;
      fade_out_len_q <= 20'd1;
      pitch_step_q   <= 24'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        spv_pkg::REG_SLICE_BEGIN:  slice_begin_q  <= cfg_data_i[11:0];
        spv_pkg::REG_SLICE_FINISH: slice_finish_q <= cfg_data_i[12:0];
        spv_pkg::REG_LOOP_MODE:    loop_mode_q    <= cfg_data_i[0];
        spv_pkg::REG_LEFT_GAIN:    left_gain_q    <= cfg_data_i[15:0];
        spv_pkg::REG_RIGHT_GAIN:   right_gain_q   <= cfg_data_i[15:0];
        spv_pkg::REG_FADE_IN_LEN:  fade_in_len_q  <= cfg_data_i[19:0];
        spv_pkg::REG_FADE_OUT_LEN: fade_out_len_q <= cfg_data_i[19:0];
        spv_pkg::REG_PITCH_STEP:   pitch_step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample store.
  logic          st_we, st_re;
  logic [AW-1:0] st_raddr;
  logic [31:0]   st_rdata;

  assign st_we    = accept && (in_ch.func == spv_pkg::FUNC_WRITE) &&
                    (32'(in_ch.address) < SAMPLE_DEPTH);
  assign st_re    = (seq_q == S_RD0) || (seq_q == S_RD1);
  assign st_raddr = (seq_q == S_RD0) ? AW'(i0) : AW'(i1);

  spv_sample_store #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (AW'(in_ch.address)),
    .wdata_i ({in_ch.right_sample, in_ch.left_sample}),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Shared divider.
  logic                       div_start, div_busy, div_done;
  logic [NUM_W-1:0]           div_num, div_rem;
  logic [DW-1:0]              div_den;
  logic [spv_pkg::QUOT_W-1:0] div_quot;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (seq_q)
      S_ENV0: begin
        if (ps_q != spv_pkg::PS_REL && elapsed_q < fi) begin
          div_start = 1'b1;
          div_num   = NUM_W'(elapsed_q) << 16;
          div_den   = DW'(fi);
        end
      end
      S_ENV1: begin
        if (ps_q == spv_pkg::PS_REL) begin
          div_start = 1'b1;
          div_num   = NUM_W'(p_q[36:0]);
          div_den   = DW'(fo);
        end else if (DW'(rem) < p_q[DW-1:0]) begin
          div_start = 1'b1;
          div_num   = NUM_W'(rem) << 16;
          div_den   = p_q[DW-1:0];
        end
      end
      S_POS: begin
        if (loop_mode_q && slice_finish_q > 13'(slice_begin_q) && pos_n >= fin_pos) begin
          div_start = 1'b1;
          div_num   = NUM_W'(pos_n - beg_pos);
          div_den   = DW'(fin_pos - beg_pos);
        end
      end
      default: ;
    endcase
  end

  spv_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Shared multiplier operands.
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [16:0] diff;
  logic signed [16:0] interp;
  logic signed [16:0] frac_part;

  assign diff      = side_q ? (17'(s1_r_q) - 17'(s0_r_q)) : (17'(s1_l_q) - 17'(s0_l_q));
  assign frac_part = 17'(p_q >>> FRAC_BITS);
  assign interp    = (side_q ? 17'(s0_r_q) : 17'(s0_l_q)) + frac_part;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (seq_q)
      S_ENV0: begin
        if (ps_q == spv_pkg::PS_REL) begin
          mul_a = 34'($signed({1'b0, release_from_q}));
          mul_b = 25'($signed({1'b0, fo - rel_d}));
        end else begin
          mul_a = 34'($signed({1'b0, fo}));
          mul_b = 25'($signed({1'b0, step}));
        end
      end
      S_INT: begin
        mul_a = 34'(diff);
        mul_b = 25'($signed({1'b0, frac}));
      end
      S_SMP: begin
        mul_a = 34'(interp);
        mul_b = 25'($signed({1'b0, env_q}));
      end
      S_GAIN: begin
        mul_a = 34'($signed(p_q[32:0]));
        mul_b = 25'($signed({1'b0, side_q ? right_gain_q : left_gain_q}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 59'(mul_a * mul_b);
  end

  // Saturating output scale.
  logic signed [27:0] scaled;
  logic signed [15:0] sat;
  assign scaled = 28'(p_q >>> 31);
  always_comb begin
    if (scaled > 28'sd32767) begin
      sat = 16'sh7FFF;
    end else if (scaled < -28'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = scaled[15:0];
    end
  end

  logic [1:0] ps_fin;
  always_comb begin
    ps_fin = ps_q;
    if (ps_q == spv_pkg::PS_REL && release_cnt_q >= fo) begin
      ps_fin = spv_pkg::PS_IDLE;
    end
    if (!loop_mode_q && pos_q >= fin_pos) begin
      ps_fin = spv_pkg::PS_IDLE;
    end
  end

  // Sequencer and voice state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q          <= S_IDLE;
      side_q         <= 1'b0;
      pos_q          <= '0;
      ps_q           <= spv_pkg::PS_IDLE;
      elapsed_q      <= '0;
      release_cnt_q  <= '0;
      env_q          <= '0;
      release_from_q <= '0;
      s0_l_q         <= '0;
      s0_r_q         <= '0;
      s1_l_q         <= '0;
      s1_r_q         <= '0;
      res_l_q        <= '0;
      res_r_q        <= '0;
      oleft_q        <= '0;
      oright_q       <= '0;
      ovalid_q       <= 1'b0;
      oactive_q      <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (seq_q)
        S_IDLE: begin
          if (accept) begin
            oleft_q  <= '0;
            oright_q <= '0;
            ovalid_q <= 1'b1;
            oactive_q <= (ps_q != spv_pkg::PS_IDLE);
            unique case (in_ch.func)
              spv_pkg::FUNC_START: begin
                pos_q     <= beg_pos;
                elapsed_q <= '0;
                env_q     <= '0;
                ps_q      <= spv_pkg::PS_PLAY;
                oactive_q <= 1'b1;
              end
              spv_pkg::FUNC_RELEASE: begin
                if (ps_q != spv_pkg::PS_IDLE) begin
                  ps_q           <= spv_pkg::PS_REL;
                  release_from_q <= env_q;
                  release_cnt_q  <= '0;
                end
              end
              spv_pkg::FUNC_STOP: begin
                ps_q      <= spv_pkg::PS_IDLE;
                oactive_q <= 1'b0;
              end
              spv_pkg::FUNC_TICK: begin
                if (ps_q != spv_pkg::PS_IDLE) begin
                  ovalid_q <= 1'b0;
                  seq_q    <= S_ENV0;
                end
              end
              default: ;
            endcase
          end
        end
        S_ENV0: begin
          if (ps_q == spv_pkg::PS_REL) begin
            seq_q <= S_ENV1;
          end else if (elapsed_q < fi) begin
            seq_q <= S_DIVW;
          end else if (!loop_mode_q) begin
            if (pos_q >= fin_pos) begin
              env_q <= '0;
              seq_q <= S_RD0;
            end else begin
              seq_q <= S_ENV1;
            end
          end else begin
            env_q <= spv_pkg::ENV_FULL;
            seq_q <= S_RD0;
          end
        end
        S_ENV1: begin
          if (div_start) begin
            seq_q <= S_DIVW;
          end else begin
            env_q <= spv_pkg::ENV_FULL;
            seq_q <= S_RD0;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            env_q <= div_quot;
            seq_q <= S_RD0;
          end
        end
        S_RD0: seq_q <= S_RD1;
        S_RD1: begin
          s0_l_q <= in0 ? st_rdata[15:0] : '0;
          s0_r_q <= in0 ? st_rdata[31:16] : '0;
          seq_q  <= S_RD2;
        end
        S_RD2: begin
          // Past the last entry the upper neighbor repeats the lower one.
          s1_l_q <= in1 ? st_rdata[15:0] : s0_l_q;
          s1_r_q <= in1 ? st_rdata[31:16] : s0_r_q;
          side_q <= 1'b0;
          seq_q  <= S_INT;
        end
        S_INT:  seq_q <= S_SMP;
        S_SMP:  seq_q <= S_GAIN;
        S_GAIN: seq_q <= S_OUT;
        S_OUT: begin
          if (side_q) begin
            res_r_q <= sat;
            seq_q   <= S_POS;
          end else begin
            res_l_q <= sat;
            side_q  <= 1'b1;
            seq_q   <= S_INT;
          end
        end
        S_POS: begin
          if (div_start) begin
            seq_q <= S_MODW;
          end else begin
            pos_q <= pos_n;
            seq_q <= S_FIN;
          end
        end
        S_MODW: begin
          if (div_done) begin
            pos_q <= beg_pos + div_rem[POS_W-1:0];
            seq_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ovalid_q || out_ch.ready) begin
            if (ps_q == spv_pkg::PS_REL) begin
              if (release_cnt_q != spv_pkg::CNT_MAX) begin
                release_cnt_q <= release_cnt_q + 20'd1;
              end
            end else if (elapsed_q != spv_pkg::CNT_MAX) begin
              elapsed_q <= elapsed_q + 20'd1;
            end
            ps_q      <= ps_fin;
            oleft_q   <= res_l_q;
            oright_q  <= res_r_q;
            oactive_q <= (ps_fin != spv_pkg::PS_IDLE);
            ovalid_q  <= 1'b1;
            seq_q     <= S_IDLE;
          end
        end
        default: seq_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = ovalid_q;
  assign out_ch.out_left  = oleft_q;
  assign out_ch.out_right = oright_q;
  assign out_ch.active    = oactive_q;

`ifndef NO_ASSERTIONS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_DIVW && div_done) |=> env_q <= spv_pkg::ENV_FULL)
    else $error("envelope above full scale");

  a_wrap_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_MODW && div_done) |=> pos_q < fin_pos)
    else $error("loop wrap left position past the slice end");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !$past(ovalid_q && !out_ch.ready)) |->
      $past(seq_q == S_FIN || accept))
    else $error("result appeared without a finished item");
`endif
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the sample playback voice.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DEPTH = 4096;
  localparam int unsigned FRAC = 16;
  localparam longint unsigned POS_MASK = (64'd1 << (13 + FRAC)) - 1;
  localparam int PAUSE = 60;

  typedef struct {
    logic [2:0]         func;
    logic [11:0]        address;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } voice_item_t;

  typedef struct {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               active;
  } voice_out_t;

  class voice_scoreboard;
    logic [31:0]     store [int];
    longint unsigned pos;
    logic [1:0]      pstate;
    longint unsigned elapsed, rel_cnt, env, rel_from;
    longint unsigned sl_begin, sl_finish, loop_on, gain_l, gain_r, fade_in, fade_out, step;
    voice_out_t      expected_q[$];
    int              mismatches, outputs_seen, ticks_played;

    function new();
      pos = 0; pstate = spv_pkg::PS_IDLE; elapsed = 0; rel_cnt = 0; env = 0; rel_from = 0;
      sl_begin = 0; sl_finish = 4096; loop_on = 0; gain_l = 32768; gain_r = 32768;
      fade_in = 1; fade_out = 1; step = 65536;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        spv_pkg::REG_SLICE_BEGIN:  sl_begin = val[11:0];
        spv_pkg::REG_SLICE_FINISH: sl_finish = val[12:0];
        spv_pkg::REG_LOOP_MODE:    loop_on = val[0];
        spv_pkg::REG_LEFT_GAIN:    gain_l = val[15:0];
        spv_pkg::REG_RIGHT_GAIN:   gain_r = val[15:0];
        spv_pkg::REG_FADE_IN_LEN:  fade_in = val[19:0];
        spv_pkg::REG_FADE_OUT_LEN: fade_out = val[19:0];
        default:                   step = val[23:0];
      endcase
    endfunction

    function longint read_side(longint unsigned p, bit hi);
      longint unsigned i0;
      longint frac, s0, s1;
      logic [31:0] w;
      i0 = p >> FRAC;
      frac = longint'(p & ((64'd1 << FRAC) - 1));
      if (i0 >= DEPTH) return 0;
      w = store[int'(i0)];
      s0 = hi ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
      s1 = s0;
      if (i0 + 1 < DEPTH) begin
        w = store[int'(i0 + 1)];
        s1 = hi ? longint'($signed(w[31:16])) : longint'($signed(w[15:0]));
      end
      return s0 + (((s1 - s0) * frac) >>> FRAC);
    endfunction

    function logic signed [15:0] scale(longint s, longint unsigned gain);
      longint v;
      v = (s * longint'(env) * longint'(gain)) >>> 31;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void tick(ref voice_out_t r);
      longint unsigned fo, fi, st, fin, beg, d, rem, span;
      fo = fade_out ? fade_out : 1;
      fi = fade_in ? fade_in : 1;
      st = step ? step : 1;
      beg = sl_begin << FRAC;
      fin = sl_finish << FRAC;
      if (pstate == spv_pkg::PS_REL) begin
        d = rel_cnt < fo ? rel_cnt : fo;
        env = (rel_from * (fo - d)) / fo;
        if (rel_cnt >= fo) pstate = spv_pkg::PS_IDLE;
        if (rel_cnt < spv_pkg::CNT_MAX) rel_cnt++;
      end else begin
        if (elapsed < fi) env = (elapsed * spv_pkg::ENV_FULL) / fi;
        else if (!loop_on) begin
          if (pos >= fin) env = 0;
          else begin
            rem = fin - pos;
            span = fo * st;
            env = rem < span ? (rem * spv_pkg::ENV_FULL) / span : spv_pkg::ENV_FULL;
          end
        end else env = spv_pkg::ENV_FULL;
        if (elapsed < spv_pkg::CNT_MAX) elapsed++;
      end
      r.out_left = scale(read_side(pos, 0), gain_l);
      r.out_right = scale(read_side(pos, 1), gain_r);
      pos = (pos + st) & POS_MASK;
      if (loop_on) begin
        if (fin > beg && pos >= fin) pos = beg + (pos - beg) % (fin - beg);
      end else if (pos >= fin) pstate = spv_pkg::PS_IDLE;
      ticks_played++;
    endfunction

    // Predicts the result of one accepted input transaction.
    function void note_input(voice_item_t it);
      voice_out_t r;
      r.out_left = 0;
      r.out_right = 0;
      case (it.func)
        spv_pkg::FUNC_WRITE: store[int'(it.address)] = {it.right_sample, it.left_sample};
        spv_pkg::FUNC_START: begin
          pos = (sl_begin << FRAC) & POS_MASK;
          elapsed = 0; env = 0; pstate = spv_pkg::PS_PLAY;
        end
        spv_pkg::FUNC_RELEASE: if (pstate != spv_pkg::PS_IDLE) begin
          pstate = spv_pkg::PS_REL; rel_from = env; rel_cnt = 0;
        end
        spv_pkg::FUNC_STOP: pstate = spv_pkg::PS_IDLE;
        spv_pkg::FUNC_TICK: if (pstate != spv_pkg::PS_IDLE) tick(r);
        default: ;
      endcase
      r.active = pstate != spv_pkg::PS_IDLE;
      expected_q.push_back(r);
    endfunction

    function void check_output(voice_out_t got);
      voice_out_t want;
      outputs_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output transaction %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
          got.active !== want.active) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output %0d expected L=%0d R=%0d act=%0b, got L=%0d R=%0d act=%0b",
                   outputs_seen, want.out_left, want.out_right, want.active,
                   got.out_left, got.out_right, got.active);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spv_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [spv_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  bit stall_free = 1'b0;
  bit gap_free = 1'b0;
  int stall_left = 0;
  int items_sent = 0;

  spv_in_if in_ch ();
  spv_out_if out_ch ();

  sample_playback_voice dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  voice_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = spv_pkg::FUNC_STOP;
    in_ch.address = '0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: accept, then draw a stall for the next transaction.
  always @(posedge clk_i) begin
    voice_out_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_left = out_ch.out_left;
        got.out_right = out_ch.out_right;
        got.active = out_ch.active;
        sb.check_output(got);
        stall_left = stall_free ? 0 : int'($urandom_range(0, 10));
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  task automatic send(voice_item_t it);
    int gap;
    gap = gap_free ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.address <= it.address;
    in_ch.left_sample <= it.left_sample;
    in_ch.right_sample <= it.right_sample;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_op(logic [2:0] func);
    voice_item_t it;
    it.func = func;
    it.address = 12'($urandom);
    it.left_sample = 16'($urandom);
    it.right_sample = 16'($urandom);
    send(it);
  endtask

  task automatic send_write(int addr, logic [15:0] l, logic [15:0] r);
    voice_item_t it;
    it.func = spv_pkg::FUNC_WRITE;
    it.address = 12'(addr);
    it.left_sample = l;
    it.right_sample = r;
    send(it);
  endtask

  // A tick of a playing voice reads two neighboring entries; fill them first if new.
  task automatic send_tick();
    longint unsigned i0;
    if (sb.pstate != spv_pkg::PS_IDLE) begin
      i0 = sb.pos >> FRAC;
      if (i0 < DEPTH && !sb.store.exists(int'(i0)))
        send_write(int'(i0), 16'($urandom), 16'($urandom));
      if (i0 + 1 < DEPTH && !sb.store.exists(int'(i0 + 1)))
        send_write(int'(i0 + 1), 16'($urandom), 16'($urandom));
    end
    send_op(spv_pkg::FUNC_TICK);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (PAUSE) @(posedge clk_i);
  endtask

  task automatic configure(logic [23:0] vals[8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= i[2:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(i[2:0], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] vals[8];
    int b, roll, start_cnt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme samples, every function, idle ticks, the last store entry.
    send_op(spv_pkg::FUNC_TICK);
    send_op(spv_pkg::FUNC_RELEASE);
    send_write(0, 16'h7FFF, 16'h8000);
    send_write(1, 16'h8000, 16'h7FFF);
    send_write(DEPTH - 1, 16'hFFFF, 16'h0000);
    send_op(3'd5);
    send_op(3'd6);
    send_op(3'd7);
    send_op(spv_pkg::FUNC_START);
    repeat (3) send_tick();
    send_op(spv_pkg::FUNC_RELEASE);
    send_tick();
    send_op(spv_pkg::FUNC_RELEASE);
    repeat (3) send_tick();
    send_op(spv_pkg::FUNC_START);
    send_op(spv_pkg::FUNC_STOP);
    send_op(spv_pkg::FUNC_TICK);
    vals = '{24'd4095, 24'd4096, 24'd0, 24'd65535, 24'd32768, 24'd2, 24'd3, 24'd32768};
    configure(vals);
    send_op(spv_pkg::FUNC_START);
    repeat (6) send_tick();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 12; ph++) begin
      b = int'($urandom_range(0, 4000));
      vals[0] = 24'(b);
      vals[1] = 24'(b + int'($urandom_range(1, 64)));
      vals[2] = 24'($urandom_range(0, 1));
      vals[3] = 24'($urandom_range(0, 32768));
      vals[4] = 24'($urandom_range(0, 32768));
      vals[5] = 24'($urandom_range(1, 40));
      vals[6] = 24'($urandom_range(1, 40));
      vals[7] = 24'($urandom_range(4096, 200000));
      case (ph)
        0: vals = '{24'd0, 24'd4096, 24'd0, 24'd32768, 24'd32768, 24'd1, 24'd1, 24'd65536};
        1: begin
          vals[5] = '0; vals[6] = '0; vals[7] = '0; vals[3] = '0; vals[4] = 24'd65535;
        end
        2: begin vals[7] = 24'hFFFFFF; vals[1] = 24'd8191; end
        3: begin vals[5] = 24'hFFFFF; vals[6] = 24'hFFFFF; vals[2] = 24'd1; end
        4: begin vals[1] = '0; vals[2] = 24'd1; vals[7] = 24'hFFFFFF; end
        5: begin vals[0] = 24'd4095; vals[1] = 24'd4096; end
        default: ;
      endcase
      configure(vals);
      gap_free = (ph % 4 == 1);
      stall_free = (ph % 4 == 2);
      start_cnt = items_sent;
      while (items_sent - start_cnt < 80) begin
        roll = int'($urandom_range(0, 99));
        if (sb.pstate == spv_pkg::PS_IDLE && roll < 60) send_op(spv_pkg::FUNC_START);
        else if (roll < 3) send_op(spv_pkg::FUNC_START);
        else if (roll < 6) send_op(spv_pkg::FUNC_RELEASE);
        else if (roll < 8) send_op(spv_pkg::FUNC_STOP);
        else if (roll < 10) send_op(3'($urandom_range(5, 7)));
        else if (roll < 14)
          send_write(int'($urandom_range(0, DEPTH - 1)), 16'($urandom), 16'($urandom));
        else send_tick();
      end
    end
    gap_free = 0;
    stall_free = 0;
    drain();
    $display("Covered %0d output transactions, %0d of them played ticks, over 13 settings.",
             sb.outputs_seen, sb.ticks_played);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/spv_pkg.sv
rtl/core/spv_if.sv
rtl/core/spv_divider.sv
rtl/core/spv_sample_store.sv
rtl/core/sample_playback_voice.sv
tb/tb_top.sv
